>>> hw/rtl/h2r_pkg.sv
// Shared types and constants for the HSV to RGB pixel converter.
// No dependencies; every other file in hw/rtl imports this package.
package h2r_pkg;

  localparam int HUE_W  = 15;
  localparam int SV_W   = 9;
  localparam int CH_W   = 8;
  localparam int REM_W  = 12;
  localparam int PROD_W = 21;
  localparam int QN_W   = 20;
  localparam int VQ_W   = 29;
  localparam int VP_W   = 17;

  localparam logic [HUE_W-1:0]  HUE_FULL   = 15'd23040;
  localparam logic [HUE_W-1:0]  HUE_SECTOR = 15'd3840;
  localparam logic [REM_W-1:0]  REM_SECTOR = 12'd3840;
  localparam logic [SV_W-1:0]   ONE_Q8     = 9'd256;
  localparam logic [PROD_W-1:0] Q_FULL     = 21'd983040;  // 256 * 3840
  localparam logic [CH_W-1:0]   ALPHA_OUT  = 8'd255;

  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  // Scaled channel candidates, routed to red/green/blue by sector.
  typedef struct packed {
    sector_t          sector;
    logic [CH_W-1:0]  vch;
    logic [CH_W-1:0]  pch;
    logic [CH_W-1:0]  qch;
    logic [CH_W-1:0]  tch;
  } chan_t;

endpackage

>>> hw/rtl/h2r_if.sv
// Valid/ready channel interfaces for HSV pixels in and RGBA pixels out.
// Depends on h2r_pkg for field widths.
interface hsv_if;
  import h2r_pkg::*;
  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue;
  logic [SV_W-1:0]   saturation;
  logic [SV_W-1:0]   brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface rgb_if;
  import h2r_pkg::*;
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;
  logic [CH_W-1:0]  alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

>>> hw/rtl/h2r_pipe.sv
// Five-stage arithmetic pipeline: wrap/clamp, sector split, s*f products,
// v products, scale by 255. Depends on h2r_pkg and hsv_if.
module h2r_pipe (
  input  logic           clk,
  input  logic           rst,
  hsv_if.sink            hsv,
  output logic           res_valid,
  input  logic           res_ready,
  output h2r_pkg::chan_t res
);
  import h2r_pkg::*;

  localparam int NSTG = 5;

  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;

  // stage 0: wrapped hue, clamped s and v
  logic [HUE_W-1:0] h0;
  logic [SV_W-1:0]  s0, v0;
  // stage 1: sector and remainder
  sector_t          sec1;
  logic [REM_W-1:0] rem1;
  logic [SV_W-1:0]  s1, v1;
  // stage 2: s*rem, s*(sector-rem), 1-s
  sector_t           sec2;
  logic [PROD_W-1:0] pa2, pb2;
  logic [SV_W-1:0]   pn2, v2;
  // stage 3: products with v
  sector_t           sec3;
  logic [VQ_W-1:0]   vq3, vt3;
  logic [VP_W-1:0]   vp3;
  logic [SV_W-1:0]   v3;
  // stage 4: scaled channels
  chan_t             ch4;

  logic [HUE_W-1:0]  h_wrap;
  logic [SV_W-1:0]   s_clamp, v_clamp;
  sector_t           sec_next;
  logic [HUE_W-1:0]  base;
  logic [HUE_W-1:0]  rem_full;
  logic [PROD_W-1:0] pa_next, pb_next;
  logic [QN_W-1:0]   qn, tn;
  logic [32:0]       q17, t17;
  logic [24:0]       p255;
  logic [16:0]       v255;

  // A stage takes a beat when it is empty or its content moves on.
  assign rdy[NSTG] = res_ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  assign hsv.ready = rdy[0];
  assign res_valid = vld[NSTG-1];
  assign res       = ch4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= hsv.valid;
      for (int k = 1; k < NSTG; k++) begin
        if (rdy[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 0: fold hue at or above 360 degrees, saturate s and v at 1.0.
  assign h_wrap  = (hsv.hue >= HUE_FULL) ? hsv.hue - HUE_FULL : hsv.hue;
  assign s_clamp = (hsv.saturation > ONE_Q8) ? ONE_Q8 : hsv.saturation;
  assign v_clamp = (hsv.brightness > ONE_Q8) ? ONE_Q8 : hsv.brightness;

  always_ff @(posedge clk) begin
    if (rdy[0] && hsv.valid) begin
      h0 <= h_wrap;
      s0 <= s_clamp;
      v0 <= v_clamp;
    end
  end

  // Stage 1: divide by 60 degrees through threshold compares.
  always_comb begin
    priority if (h0 >= 15'(5 * 3840)) begin
      sec_next = SEC_MAGENTA;
      base     = 15'(5 * 3840);
    end else if (h0 >= 15'(4 * 3840)) begin
      sec_next = SEC_BLUE;
      base     = 15'(4 * 3840);
    end else if (h0 >= 15'(3 * 3840)) begin
      sec_next = SEC_CYAN;
      base     = 15'(3 * 3840);
    end else if (h0 >= 15'(2 * 3840)) begin
      sec_next = SEC_GREEN;
      base     = 15'(2 * 3840);
    end else if (h0 >= HUE_SECTOR) begin
      sec_next = SEC_YELLOW;
      base     = HUE_SECTOR;
    end else begin
      sec_next = SEC_RED;
      base     = '0;
    end
  end
  assign rem_full = h0 - base;

  always_ff @(posedge clk) begin
    if (rdy[1] && vld[0]) begin
      sec1 <= sec_next;
      rem1 <= rem_full[REM_W-1:0];
      s1   <= s0;
      v1   <= v0;
    end
  end

  // Stage 2: s*f and s*(1-f) in hue units.
  assign pa_next = PROD_W'(s1) * PROD_W'(rem1);
  assign pb_next = PROD_W'(s1) * PROD_W'(REM_SECTOR - rem1);

  always_ff @(posedge clk) begin
    if (rdy[2] && vld[1]) begin
      sec2 <= sec1;
      pa2  <= pa_next;
      pb2  <= pb_next;
      pn2  <= ONE_Q8 - s1;
      v2   <= v1;
    end
  end

  // Stage 3: multiply the numerators by v.
  assign qn = QN_W'(Q_FULL - pa2);
  assign tn = QN_W'(Q_FULL - pb2);

  always_ff @(posedge clk) begin
    if (rdy[3] && vld[2]) begin
      sec3 <= sec2;
      vq3  <= VQ_W'(v2) * VQ_W'(qn);
      vt3  <= VQ_W'(v2) * VQ_W'(tn);
      vp3  <= VP_W'(v2) * VP_W'(pn2);
      v3   <= v2;
    end
  end

  // Stage 4: 255 / (65536 * 3840) reduces to 17 / 2^24 for q and t.
  assign q17  = 33'(vq3) + (33'(vq3) << 4);
  assign t17  = 33'(vt3) + (33'(vt3) << 4);
  assign p255 = (25'(vp3) << 8) - 25'(vp3);
  assign v255 = (17'(v3) << 8) - 17'(v3);

  always_ff @(posedge clk) begin
    if (rdy[4] && vld[3]) begin
      ch4.sector <= sec3;
      ch4.qch    <= q17[31:24];
      ch4.tch    <= t17[31:24];
      ch4.pch    <= p255[23:16];
      ch4.vch    <= v255[15:8];
    end
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    vld[NSTG-1] && !res_ready |=> vld[NSTG-1] && $stable(ch4))
    else $error("scaled channels changed under a stall");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> rem1 < REM_SECTOR)
    else $error("hue remainder outside one sector");

  a_value_max: assert property (@(posedge clk) disable iff (rst)
    vld[NSTG-1] |-> ch4.pch <= ch4.vch && ch4.qch <= ch4.vch && ch4.tch <= ch4.vch)
    else $error("channel candidate above value");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    vld[2] && !rdy[3] |=> vld[2])
    else $error("stalled stage dropped its beat");

endmodule

>>> hw/rtl/hsv_to_rgb_converter_top.sv
// Top level of the HSV to RGB pixel converter: arithmetic pipeline plus
// sector routing into the output register. Depends on h2r_pkg, h2r_if, h2r_pipe.
//
//   port   dir   beat contents
//   hsv    in    hue (15b, 1/64 deg), saturation (9b Q1.8), brightness (9b Q1.8)
//   rgb    out   red, green, blue, alpha (8b each, alpha fixed at 255)
//
// One pixel per clock sustained while rgb is not stalled; an accepted hsv beat
// passes the five arithmetic stages (the first loaded on the accept edge) and
// then the output register, whose load raises rgb.valid.
// Synchronous reset clears all valid bits; payload registers are not reset.
// Each stage has its own ready, so a stall at rgb lets bubbles close up and
// hsv keeps accepting until the pipeline is full; nothing is lost or repeated.
module hsv_to_rgb_converter_top (
  input  logic clk,
  input  logic rst,
  hsv_if.sink  hsv,
  rgb_if.source rgb
);
  import h2r_pkg::*;

  logic  pipe_valid;
  logic  pipe_ready;
  chan_t pipe_res;

  logic [CH_W-1:0] red_next, green_next, blue_next;

  h2r_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .hsv       (hsv),
    .res_valid (pipe_valid),
    .res_ready (pipe_ready),
    .res       (pipe_res)
  );

  assign pipe_ready = !rgb.valid || rgb.ready;

  always_comb begin
    unique case (pipe_res.sector)
      SEC_RED: begin
        red_next = pipe_res.vch; green_next = pipe_res.tch; blue_next = pipe_res.pch;
      end
      SEC_YELLOW: begin
        red_next = pipe_res.qch; green_next = pipe_res.vch; blue_next = pipe_res.pch;
      end
      SEC_GREEN: begin
        red_next = pipe_res.pch; green_next = pipe_res.vch; blue_next = pipe_res.tch;
      end
      SEC_CYAN: begin
        red_next = pipe_res.pch; green_next = pipe_res.qch; blue_next = pipe_res.vch;
      end
      SEC_BLUE: begin
        red_next = pipe_res.tch; green_next = pipe_res.pch; blue_next = pipe_res.vch;
      end
      default: begin
        red_next = pipe_res.vch; green_next = pipe_res.pch; blue_next = pipe_res.qch;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rgb.valid <= 1'b0;
    end else if (pipe_ready) begin
      rgb.valid <= pipe_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_ready && pipe_valid) begin
      rgb.red   <= red_next;
      rgb.green <= green_next;
      rgb.blue  <= blue_next;
    end
  end

  assign rgb.alpha = ALPHA_OUT;

  a_take_to_out: assert property (@(posedge clk) disable iff (rst)
    pipe_valid && pipe_ready |=> rgb.valid)
    else $error("beat taken from pipeline did not reach output");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    rgb.valid && !rgb.ready |=> rgb.valid && $stable({rgb.red, rgb.green, rgb.blue}))
    else $error("output beat changed under a stall");

  a_grey_sector_free: assert property (@(posedge clk) disable iff (rst)
    pipe_valid && pipe_ready && pipe_res.pch == pipe_res.vch
      |=> rgb.red == rgb.green && rgb.green == rgb.blue)
    else $error("grey pixel not equal on all channels");

endmodule
